[rtl/core/rgtd_pkg.sv]
package rgtd_pkg;

    // Text store geometry: four characters per row
    localparam int TEXT_ROWS  = 16;
    localparam int ROW_CHARS  = 4;
    localparam int NAME_CHARS = 8;

    // Group types handled
    localparam logic [3:0] GT_NAME = 4'h0;
    localparam logic [3:0] GT_TEXT = 4'h2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_NO_SYNC,
        ST_DUP,
        ST_NAME,
        ST_TEXT,
        ST_OTHER,
        ST_READ
    } status_t;

    typedef logic [ROW_CHARS-1:0][6:0] text_row_t;

    typedef struct packed {
        logic        req_type;
        logic        group_sync;
        logic [15:0] block_a;
        logic [15:0] block_b;
        logic [15:0] block_c;
        logic [15:0] block_d;
        logic        read_store;
        logic [5:0]  read_index;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  write_position;
        logic [7:0]  char_one;
        logic [7:0]  char_two;
        logic [7:0]  char_three;
        logic [7:0]  char_four;
        logic        text_cleared;
        logic        name_ready;
    } result_t;

    // Write command toward the text store
    typedef struct packed {
        logic      en;
        logic      clear;
        logic [3:0] row;
        text_row_t data;
    } text_wr_t;

    // Character set map for bytes 0x7F..0x9E
    localparam logic [7:0] CODE_MAP [32] = '{
        8'hE0, 8'h85, 8'h82, 8'h8A, 8'hE1, 8'h8D, 8'hE2, 8'h95,
        8'hE3, 8'h97, 8'h9C, 8'h80, 8'h20, 8'h00, 8'hE9, 8'h20,
        8'h83, 8'h84, 8'h88, 8'h89, 8'h86, 8'h8B, 8'h93, 8'h94,
        8'h96, 8'h81, 8'h9B, 8'h87, 8'h20, 8'h20, 8'h20, 8'h20
    };

    function automatic logic [7:0] convert_char(input logic [7:0] b);
        logic [7:0] off;
        off = b - 8'h7F;
        if (b < 8'h7F)
            return b;
        else if (b <= 8'h9E)
            return CODE_MAP[off[4:0]];
        else
            return 8'h20;
    endfunction

    function automatic logic printable(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

endpackage

[rtl/core/rgtd_text_mem.sv]
module rgtd_text_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [3:0]        rd_row,
    input  rgtd_pkg::text_wr_t wr,
    output rgtd_pkg::text_row_t rd_data
);
    import rgtd_pkg::*;

    text_row_t              mem [TEXT_ROWS];
    text_row_t              rd_word_reg;
    logic                   rd_ok_reg;
    logic [TEXT_ROWS-1:0]   valid_reg;
    logic [TEXT_ROWS-1:0]   valid_next;

    // Drop all rows on clear, then mark the written row
    always_comb
    begin
        valid_next = wr.clear ? '0 : valid_reg;
        if (wr.en)
            valid_next[wr.row] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
                rd_ok_reg <= valid_next[rd_row];
        end
    end

    // Write one row; read with bypass of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.row] <= wr.data;
        if (rd_en)
            rd_word_reg <= (wr.en && (wr.row == rd_row)) ? wr.data : mem[rd_row];
    end

    // Rows never written since the last clear read as zero
    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> valid_reg[$past(wr.row)])
        else $error("written text row not marked valid");

endmodule

[rtl/core/rgtd_group_proc.sv]
module rgtd_group_proc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rgtd_pkg::item_t     item,
    input  rgtd_pkg::text_row_t text_word,
    output rgtd_pkg::result_t   res,
    output rgtd_pkg::text_wr_t  wr
);
    import rgtd_pkg::*;

    logic [63:0] last_reg;
    logic [63:0] last_next;
    logic [7:0]  name_reg  [NAME_CHARS];
    logic [7:0]  name_next [NAME_CHARS];
    logic        ab_reg;
    logic        ab_next;
    logic [63:0] grp;
    logic [2:0]  npos;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [6:0]  tchar;
    text_wr_t    wr_cmd;

    assign grp = {item.block_a, item.block_b, item.block_c, item.block_d};
    assign npos = {item.block_b[1:0], 1'b0};
    assign c1 = convert_char(item.block_d[15:8]);
    assign c2 = convert_char(item.block_d[7:0]);
    assign tchar = text_word[item.read_index[1:0]];

    // Decode one word against the stored state
    always_comb
    begin
        res = '0;
        wr_cmd = '0;
        last_next = last_reg;
        ab_next = ab_reg;
        name_next = name_reg;
        if (item.req_type)
        begin
            res.status = ST_READ;
            if (!item.read_store)
                res.char_one = (item.read_index[5:3] == 3'd0) ?
                               name_reg[item.read_index[2:0]] : 8'h00;
            else
                res.char_one = (tchar == 7'd0) ? 8'h20 : {1'b0, tchar};
        end
        else if (!item.group_sync)
            res.status = ST_NO_SYNC;
        else if (grp == last_reg)
            res.status = ST_DUP;
        else
        begin
            last_next = grp;
            unique case (item.block_b[15:12])
                GT_NAME:
                begin
                    name_next[npos] = c1;
                    name_next[{item.block_b[1:0], 1'b1}] = c2;
                    res.status = ST_NAME;
                    res.write_position = {3'd0, npos};
                    res.char_one = c1;
                    res.char_two = c2;
                end
                GT_TEXT:
                begin
                    if (item.block_b[4] != ab_reg)
                    begin
                        ab_next = item.block_b[4];
                        wr_cmd.clear = 1'b1;
                        res.text_cleared = 1'b1;
                    end
                    wr_cmd.en = 1'b1;
                    wr_cmd.row = item.block_b[3:0];
                    wr_cmd.data[0] = item.block_c[14:8];
                    wr_cmd.data[1] = item.block_c[6:0];
                    wr_cmd.data[2] = item.block_d[14:8];
                    wr_cmd.data[3] = item.block_d[6:0];
                    res.status = ST_TEXT;
                    res.write_position = {item.block_b[3:0], 2'b00};
                    res.char_one = {1'b0, item.block_c[14:8]};
                    res.char_two = {1'b0, item.block_c[6:0]};
                    res.char_three = {1'b0, item.block_d[14:8]};
                    res.char_four = {1'b0, item.block_d[6:0]};
                end
                default:
                    res.status = ST_OTHER;
            endcase
        end
        res.name_ready = printable(name_next[0]) && printable(name_next[1]) &&
                         printable(name_next[2]) && printable(name_next[3]);
    end

    // Touch the text store only when the word moves on
    always_comb
    begin
        wr = wr_cmd;
        wr.en = wr_cmd.en & advance;
        wr.clear = wr_cmd.clear & advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            ab_reg <= 1'b0;
            for (int i = 0; i < NAME_CHARS; i++)
                name_reg[i] <= '0;
        end
        else if (advance)
        begin
            last_reg <= last_next;
            ab_reg <= ab_next;
            name_reg <= name_next;
        end
    end

    a_clear_with_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.clear |-> wr.en)
        else $error("text clear without a text write");

    a_flag_follows_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr.clear |=> ab_reg != $past(ab_reg))
        else $error("A/B flag did not toggle on clear");

endmodule

[rtl/core/rds_group_text_decoder.sv]
// Channel   Dir  Handshake        tuser                           tdata
// s_*       in   tvalid/tready    req_type, group_sync, read_store  blocks a..d, read_index
// m_*       out  tvalid/tready    status                          position, chars, flags
//
// One word in, one word out; a new word is taken every cycle while the output is not stalled.
// A word passes the input register, then is decoded into the output register.
// The text store is a 16-row memory whose read is issued when the word is taken.
// Reset empties both stages and clears the name store, last group and text rows.
// A stalled output holds its word; the input stage still takes one more word.
module rds_group_text_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] block_a, [31:16] block_b, [47:32] block_c, [63:48] block_d,
    // [69:64] read_index, [71:70] zero
    input  logic [71:0] s_tdata,
    // [0] req_type, [1] group_sync, [2] read_store
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] write_position, [13:6] char_one, [21:14] char_two,
    // [29:22] char_three, [37:30] char_four, [38] text_cleared, [39] name_ready
    output logic [39:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);
    import rgtd_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    item_t     in_item_reg;
    item_t     in_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic [39:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic      accept;
    logic      advance;
    result_t   res;
    text_wr_t  wr;
    text_row_t text_word;

    // Move stage one forward when the output is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next.req_type = s_tuser[0];
        in_item_next.group_sync = s_tuser[1];
        in_item_next.read_store = s_tuser[2];
        in_item_next.block_a = s_tdata[15:0];
        in_item_next.block_b = s_tdata[31:16];
        in_item_next.block_c = s_tdata[47:32];
        in_item_next.block_d = s_tdata[63:48];
        in_item_next.read_index = s_tdata[69:64];
        in_valid_next = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    rgtd_text_mem u_text_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  (s_tdata[69:66]),
        .wr      (wr),
        .rd_data (text_word)
    );

    rgtd_group_proc u_group_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .text_word (text_word),
        .res       (res),
        .wr        (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input and result words
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item_next;
        if (advance)
        begin
            out_user_reg <= res.status;
            out_data_reg <= {res.name_ready, res.text_cleared, res.char_four,
                             res.char_three, res.char_two, res.char_one,
                             res.write_position};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word lost");

    a_cleared_only_on_text: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[38]) |-> (m_tuser == ST_TEXT))
        else $error("text_cleared on a non-text result");

endmodule

[tb/rds_group_text_decoder_tb.sv]
`timescale 1ns / 1ps

module rds_group_text_decoder_tb;
    import rgtd_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_LIMIT  = 2000;

    // RDS character set for bytes 0x7F..0x9E
    localparam logic [7:0] RDS_CHARSET [32] = '{
        8'hE0, 8'h85, 8'h82, 8'h8A, 8'hE1, 8'h8D, 8'hE2, 8'h95,
        8'hE3, 8'h97, 8'h9C, 8'h80, 8'h20, 8'h00, 8'hE9, 8'h20,
        8'h83, 8'h84, 8'h88, 8'h89, 8'h86, 8'h8B, 8'h93, 8'h94,
        8'h96, 8'h81, 8'h9B, 8'h87, 8'h20, 8'h20, 8'h20, 8'h20
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    // Decoder state as the testbench sees it
    logic [63:0] seen_group;
    logic [7:0]  ps_name [8];
    logic [6:0]  rt_text [64];
    logic        rt_flag;

    // Expected output words, oldest first
    result_t     decoded_q [$];

    // Word on the input bus and its typed-in answer, if any
    item_t       cur_word;
    bit          cur_typed;
    result_t     cur_want;

    // Directed table
    item_t       dir_word [$];
    bit          dir_typed [$];
    result_t     dir_want [$];

    logic [63:0] last_sent_group;
    logic [15:0] station_pi;
    bit          txt_flag;
    bit          quiet;
    bit          hold_done;
    int          words_in;
    int          words_out;
    int          fail_count;
    int          clear_count;
    int          status_seen [6];

    always #10 clk = ~clk;

    rds_group_text_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic item_t grp(input bit sync, input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c, input logic [15:0] d);
        item_t w;
        w = '0;
        w.group_sync = sync;
        w.block_a = a;
        w.block_b = b;
        w.block_c = c;
        w.block_d = d;
        return w;
    endfunction

    function automatic item_t rd(input bit store, input logic [5:0] idx);
        item_t w;
        w = '0;
        w.req_type = 1'b1;
        w.read_store = store;
        w.read_index = idx;
        return w;
    endfunction

    function automatic result_t res(input status_t st, input logic [5:0] pos,
                                    input logic [7:0] c1, input logic [7:0] c2,
                                    input logic [7:0] c3, input logic [7:0] c4,
                                    input bit clr, input bit rdy);
        result_t r;
        r.status = st;
        r.write_position = pos;
        r.char_one = c1;
        r.char_two = c2;
        r.char_three = c3;
        r.char_four = c4;
        r.text_cleared = clr;
        r.name_ready = rdy;
        return r;
    endfunction

    function automatic string fmt_res(input result_t r);
        return $sformatf("st=%0d pos=%0d c=%02h %02h %02h %02h clr=%0b rdy=%0b",
                         r.status, r.write_position, r.char_one, r.char_two,
                         r.char_three, r.char_four, r.text_cleared, r.name_ready);
    endfunction

    // Map a program-service byte through the RDS character set
    function automatic logic [7:0] ps_byte(input logic [7:0] b);
        logic [7:0] off;
        off = b - 8'h7F;
        if (b < 8'h7F)
            return b;
        if (b <= 8'h9E)
            return RDS_CHARSET[off[4:0]];
        return 8'h20;
    endfunction

    function automatic bit in_ascii(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    // Decode one word against the tracked state and update it
    function automatic result_t decode_word(input item_t w);
        result_t     r;
        logic [63:0] g;
        logic [5:0]  pos;
        r = '0;
        r.status = ST_NO_SYNC;
        g = {w.block_a, w.block_b, w.block_c, w.block_d};
        if (w.req_type) begin
            r.status = ST_READ;
            if (!w.read_store)
                r.char_one = (w.read_index < 8) ? ps_name[w.read_index[2:0]] : 8'h00;
            else if (rt_text[w.read_index] == 7'd0)
                r.char_one = 8'h20;
            else
                r.char_one = {1'b0, rt_text[w.read_index]};
        end
        else if (w.group_sync) begin
            if (g == seen_group) begin
                r.status = ST_DUP;
            end
            else begin
                seen_group = g;
                case (w.block_b[15:12])
                    GT_NAME: begin
                        pos = {3'd0, w.block_b[1:0], 1'b0};
                        r.status = ST_NAME;
                        r.write_position = pos;
                        r.char_one = ps_byte(w.block_d[15:8]);
                        r.char_two = ps_byte(w.block_d[7:0]);
                        ps_name[pos[2:0]] = r.char_one;
                        ps_name[pos[2:0] + 3'd1] = r.char_two;
                    end
                    GT_TEXT: begin
                        pos = {w.block_b[3:0], 2'b00};
                        if (w.block_b[4] != rt_flag) begin
                            rt_flag = w.block_b[4];
                            for (int i = 0; i < 64; i++)
                                rt_text[i] = 7'd0;
                            r.text_cleared = 1'b1;
                        end
                        r.status = ST_TEXT;
                        r.write_position = pos;
                        r.char_one = {1'b0, w.block_c[14:8]};
                        r.char_two = {1'b0, w.block_c[6:0]};
                        r.char_three = {1'b0, w.block_d[14:8]};
                        r.char_four = {1'b0, w.block_d[6:0]};
                        rt_text[pos] = w.block_c[14:8];
                        rt_text[pos + 6'd1] = w.block_c[6:0];
                        rt_text[pos + 6'd2] = w.block_d[14:8];
                        rt_text[pos + 6'd3] = w.block_d[6:0];
                    end
                    default: r.status = ST_OTHER;
                endcase
            end
        end
        r.name_ready = in_ascii(ps_name[0]) && in_ascii(ps_name[1]) &&
                       in_ascii(ps_name[2]) && in_ascii(ps_name[3]);
        return r;
    endfunction

    // Mostly printable text, some mapped bytes, some anything
    function automatic logic [7:0] text_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (k < 8)
            return 8'($urandom_range(8'h7F, 8'h9E));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic add_row(input item_t w, input bit typed, input result_t want);
        dir_word = {dir_word, w};
        dir_typed = {dir_typed, typed};
        dir_want = {dir_want, want};
    endtask

    // Offer one word, hold it until taken, then maybe go idle
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        cur_word = w;
        cur_typed = typed;
        cur_want = want;
        s_tdata = {2'b00, w.read_index, w.block_d, w.block_c, w.block_b, w.block_a};
        s_tuser = {w.read_store, w.group_sync, w.req_type};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (!w.req_type && w.group_sync)
            last_sent_group = {w.block_a, w.block_b, w.block_c, w.block_d};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    // Predict on every accepted input word, check every accepted output word
    always @(posedge clk) begin : check_words
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                pred = decode_word(cur_word);
                if (cur_typed)
                    pred = cur_want;
                decoded_q = {decoded_q, pred};
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.write_position = m_tdata[5:0];
                got.char_one = m_tdata[13:6];
                got.char_two = m_tdata[21:14];
                got.char_three = m_tdata[29:22];
                got.char_four = m_tdata[37:30];
                got.text_cleared = m_tdata[38];
                got.name_ready = m_tdata[39];
                words_out++;
                if (decoded_q.size() == 0) begin
                    flag_error($sformatf("Unexpected word %0d: %s", words_out, fmt_res(got)));
                end
                else begin
                    want = decoded_q.pop_front();
                    if (got.status !== want.status ||
                        got.write_position !== want.write_position ||
                        got.char_one !== want.char_one ||
                        got.char_two !== want.char_two ||
                        got.char_three !== want.char_three ||
                        got.char_four !== want.char_four ||
                        got.text_cleared !== want.text_cleared ||
                        got.name_ready !== want.name_ready)
                        flag_error($sformatf("Mismatch on word %0d: expected %s, got %s",
                                             words_out, fmt_res(want), fmt_res(got)));
                    if (want.status <= ST_READ)
                        status_seen[int'(want.status)]++;
                    if (want.text_cleared)
                        clear_count++;
                end
            end
        end
    end

    // Output side: random stalls, one long hold-off, none at the end
    initial begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (!hold_done && words_in >= HOLD_AFTER) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (quiet || $urandom_range(0, 3) != 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
            else begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Timeout with %0d words outstanding", decoded_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, directed table, random traffic, drain, verdict
    initial begin : stimulus
        item_t       w;
        logic [15:0] b;
        int          sel;
        int          drain;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cur_word = '0;
        cur_typed = 1'b0;
        cur_want = '0;
        seen_group = '0;
        rt_flag = 1'b0;
        for (int i = 0; i < 8; i++)
            ps_name[i] = 8'h00;
        for (int i = 0; i < 64; i++)
            rt_text[i] = 7'd0;
        for (int i = 0; i < 6; i++)
            status_seen[i] = 0;
        last_sent_group = '0;
        station_pi = 16'h1234;
        txt_flag = 1'b0;
        quiet = 1'b0;
        hold_done = 1'b0;
        words_in = 0;
        words_out = 0;
        fail_count = 0;
        clear_count = 0;

        // All-zero group right after reset matches the cleared last group
        add_row(grp(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1,
                res(ST_DUP, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        add_row(grp(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                res(ST_NO_SYNC, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        add_row(rd(0, 6'd0), 1, res(ST_READ, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        // Unset radiotext reads as space
        add_row(rd(1, 6'd63), 1, res(ST_READ, 0, 8'h20, 8'h00, 8'h00, 8'h00, 0, 0));
        // Name position past seven reads as zero
        add_row(rd(0, 6'd63), 1, res(ST_READ, 0, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        add_row(grp(1, 16'h1234, 16'h0000, 16'h0000, 16'h5241), 0, '0);
        // Ends of the mapped range
        add_row(grp(1, 16'h1234, 16'h0001, 16'h0000, 16'h7F9E), 1,
                res(ST_NAME, 6'd2, 8'hE0, 8'h20, 8'h00, 8'h00, 0, 0));
        // Map entry of zero, and a byte above the map
        add_row(grp(1, 16'h1234, 16'h0002, 16'h0000, 16'h8CFF), 1,
                res(ST_NAME, 6'd4, 8'h00, 8'h20, 8'h00, 8'h00, 0, 0));
        add_row(grp(1, 16'h1234, 16'h0FFF, 16'hFFFF, 16'h9F7E), 0, '0);
        add_row(grp(1, 16'h1234, 16'h0001, 16'h0000, 16'h4449), 0, '0);
        add_row(grp(1, 16'h1234, 16'h0001, 16'h0000, 16'h4449), 0, '0);
        add_row(grp(1, 16'h1234, 16'h2000, 16'hFFFF, 16'h8000), 0, '0);
        add_row(rd(1, 6'd2), 0, '0);
        // Flag change clears the text
        add_row(grp(1, 16'h1234, 16'h201F, 16'h4142, 16'h4344), 0, '0);
        add_row(rd(1, 6'd0), 1, res(ST_READ, 0, 8'h20, 8'h00, 8'h00, 8'h00, 0, 1));
        add_row(rd(1, 6'd63), 0, '0);
        add_row(grp(1, 16'h1234, 16'h2FFF, 16'h00FF, 16'h7F01), 0, '0);
        add_row(grp(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0);
        add_row(grp(1, 16'h0000, 16'h1234, 16'h5678, 16'h9ABC), 0, '0);
        add_row(rd(0, 6'd7), 0, '0);
        add_row(rd(0, 6'd8), 0, '0);
        add_row(rd(1, 6'd60), 0, '0);
        add_row(grp(1, 16'h0000, 16'h0000, 16'h0000, 16'h0001), 0, '0);
        add_row(grp(1, 16'h1234, 16'h2005, 16'h5A5A, 16'hA5A5), 0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_word[i])
            send_word(dir_word[i], dir_typed[i], dir_want[i]);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= RANDOM_WORDS - QUIET_TAIL);
            if ($urandom_range(0, 49) == 0)
                station_pi = 16'($urandom);
            w = '0;
            w.block_a = 16'($urandom);
            w.block_b = 16'($urandom);
            w.block_c = 16'($urandom);
            w.block_d = 16'($urandom);
            w.read_store = 1'($urandom);
            w.read_index = 6'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                // read back a stored character
                w.req_type = 1'b1;
                w.group_sync = 1'($urandom);
                if (!w.read_store && $urandom_range(0, 4) != 0)
                    w.read_index = 6'($urandom_range(0, 7));
            end
            else if (sel < 30) begin
                // group without sync
                w.group_sync = 1'b0;
            end
            else if (sel < 38) begin
                // repeat the last synced group
                w = grp(1, last_sent_group[63:48], last_sent_group[47:32],
                        last_sent_group[31:16], last_sent_group[15:0]);
            end
            else begin
                // fresh group, mostly name or text
                w.group_sync = 1'b1;
                if ($urandom_range(0, 6) != 0)
                    w.block_a = station_pi;
                b = w.block_b;
                sel = $urandom_range(0, 9);
                if (sel < 4) begin
                    b[15:12] = GT_NAME;
                end
                else if (sel < 8) begin
                    b[15:12] = GT_TEXT;
                    if ($urandom_range(0, 11) == 0)
                        txt_flag = ~txt_flag;
                    b[4] = txt_flag;
                end
                w.block_b = b;
                w.block_c = {text_byte(), text_byte()};
                w.block_d = {text_byte(), text_byte()};
            end
            send_word(w, 1'b0, '0);
        end
        s_tvalid = 1'b0;

        // Drain outstanding words, then allow for the pipeline
        drain = 0;
        while (decoded_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (decoded_q.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", decoded_q.size()));

        $display("Checked %0d words (%0d directed, %0d random), %0d failures",
                 words_out, dir_word.size(), RANDOM_WORDS, fail_count);
        $display("Name %0d, text %0d (clears %0d), read %0d, dup %0d, no sync %0d, other %0d",
                 status_seen[ST_NAME], status_seen[ST_TEXT], clear_count,
                 status_seen[ST_READ], status_seen[ST_DUP], status_seen[ST_NO_SYNC],
                 status_seen[ST_OTHER]);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
